@@ hdl/sfpc_pkg.sv @@
package sfpc_pkg;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int DATA_W    = 32;
  localparam int RAW_W     = 14;
  localparam int PROD_W    = DATA_W + RAW_W;
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW   = 2'd2;

  localparam logic [DATA_W-1:0] GAIN_RESET = 32'h0001_0000;

  // frame bytes
  localparam logic [BYTE_W-1:0] PRE_BYTE  = 8'hFE;
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h68;
  localparam logic [BYTE_W-1:0] END_BYTE  = 8'h16;

  // raw value window and replacement
  localparam logic [2*BYTE_W-1:0] RAW_MIN = 16'd479;
  localparam logic [2*BYTE_W-1:0] RAW_MAX = 16'd3180;
  localparam logic signed [RAW_W-1:0] RAW_BAD = -14'sd5000;

  // Q16.16 limits
  localparam logic signed [DATA_W-1:0] WIN_LO    = 32'sd65536000;
  localparam logic signed [DATA_W-1:0] WIN_HI    = 32'sd131072000;
  localparam logic signed [DATA_W:0]   SLEW_STEP = 33'sd1310720;
  localparam logic signed [DATA_W-1:0] SAT_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN   = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain;
    logic signed [DATA_W-1:0] offset;
    logic                     slew_en;
  } cfg_regs_t;

  // frame end event from the parser
  typedef struct packed {
    logic valid;
    logic proc;
  } frame_evt_t;

endpackage

@@ hdl/sfpc_in_if.sv @@
interface sfpc_in_if import sfpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hdl/sfpc_out_if.sv @@
interface sfpc_out_if import sfpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     processed;
  logic signed [DATA_W-1:0] distance;
  logic                     height_updated;
  logic signed [DATA_W-1:0] height;

  modport source (output valid, output processed, output distance,
                  output height_updated, output height, input ready);
  modport sink (input valid, input processed, input distance,
                input height_updated, input height, output ready);
endinterface

@@ hdl/sfpc_cfg_if.sv @@
interface sfpc_cfg_if import sfpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/sfpc_parser.sv @@
module sfpc_parser import sfpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic [BYTE_W-1:0] raw_lo,
  output logic [BYTE_W-1:0] raw_hi,
  output frame_evt_t        evt
);

  localparam logic [3:0] STEP_HUNT   = 4'd0;
  localparam logic [3:0] STEP_PRE1   = 4'd1;
  localparam logic [3:0] STEP_PRE2   = 4'd2;
  localparam logic [3:0] STEP_SYNC   = 4'd3;
  localparam logic [3:0] STEP_PAY0   = 4'd4;
  localparam logic [3:0] STEP_RAW_LO = 4'd8;
  localparam logic [3:0] STEP_RAW_HI = 4'd9;
  localparam logic [3:0] STEP_PAYL   = 4'd11;
  localparam logic [3:0] STEP_CSUM   = 4'd12;
  localparam logic [3:0] STEP_END    = 4'd13;

  logic [3:0]        step_r, step_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] raw_lo_r, raw_lo_nxt;
  logic [BYTE_W-1:0] raw_hi_r, raw_hi_nxt;
  logic [1:0]        div_r, div_nxt;
  frame_evt_t        evt_nxt;

  // frame state walk for one accepted byte
  always_comb begin
    step_nxt   = step_r;
    sum_nxt    = sum_r;
    raw_lo_nxt = raw_lo_r;
    raw_hi_nxt = raw_hi_r;
    div_nxt    = div_r;
    evt_nxt    = '0;
    if (accept) begin
      if (step_r == STEP_HUNT || step_r > STEP_END) begin
        step_nxt = (rx_byte == PRE_BYTE) ? STEP_PRE1 : STEP_HUNT;
        if (rx_byte == PRE_BYTE) begin
          sum_nxt = '0;
        end
      end else if (step_r == STEP_PRE1 || step_r == STEP_PRE2) begin
        step_nxt = (rx_byte == PRE_BYTE) ? step_r + 4'd1 : STEP_HUNT;
      end else if (step_r == STEP_SYNC) begin
        if (rx_byte == SYNC_BYTE) begin
          step_nxt = STEP_PAY0;
          sum_nxt  = '0;
        end else begin
          step_nxt = STEP_HUNT;
        end
      end else if (step_r <= STEP_PAYL) begin
        sum_nxt = (step_r == STEP_PAY0) ? rx_byte : sum_r + rx_byte;
        if (step_r == STEP_RAW_LO) begin
          raw_lo_nxt = rx_byte;
        end
        if (step_r == STEP_RAW_HI) begin
          raw_hi_nxt = rx_byte;
        end
        step_nxt = step_r + 4'd1;
      end else if (step_r == STEP_CSUM) begin
        step_nxt = (sum_r == rx_byte) ? STEP_END : STEP_HUNT;
      end else begin
        // end byte: every valid frame gives a result, every fourth is calibrated
        step_nxt = STEP_HUNT;
        if (rx_byte == END_BYTE) begin
          evt_nxt.valid = 1'b1;
          evt_nxt.proc  = (div_r == 2'd3);
          div_nxt       = div_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_HUNT;
      sum_r    <= '0;
      raw_lo_r <= '0;
      raw_hi_r <= '0;
      div_r    <= '0;
    end else begin
      step_r   <= step_nxt;
      sum_r    <= sum_nxt;
      raw_lo_r <= raw_lo_nxt;
      raw_hi_r <= raw_hi_nxt;
      div_r    <= div_nxt;
    end
  end

  assign raw_lo = raw_lo_r;
  assign raw_hi = raw_hi_r;
  assign evt    = evt_nxt;

endmodule

@@ hdl/sfpc_calib.sv @@
module sfpc_calib import sfpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_regs_t         cfg,
  input  logic [BYTE_W-1:0] raw_lo,
  input  logic [BYTE_W-1:0] raw_hi,
  input  frame_evt_t        evt,
  output logic              stall,
  sfpc_out_if.source        out_ch
);

  logic [2*BYTE_W-1:0]       raw_u;
  logic signed [RAW_W-1:0]   raw_s;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [DATA_W:0]    hi_lim_r, lo_lim_r;
  logic signed [DATA_W-1:0]  last_height_r, last_height_nxt;

  logic                      eval_v_r, eval_v_nxt;
  logic                      eval_proc_r, eval_proc_nxt;
  logic                      fire;

  logic signed [PROD_W:0]    acc;
  logic                      ovf;
  logic signed [DATA_W-1:0]  dist_val;
  logic signed [DATA_W:0]    dist_x;
  logic signed [DATA_W:0]    h_x;
  logic                      in_win;

  logic                      out_valid_r, out_valid_nxt;
  logic                      processed_r;
  logic signed [DATA_W-1:0]  distance_r;
  logic                      updated_r;
  logic signed [DATA_W-1:0]  height_r;

  // raw value with out-of-range replacement
  always_comb begin
    raw_u = {raw_hi, raw_lo};
    if (raw_u < RAW_MIN || raw_u > RAW_MAX) begin
      raw_s = RAW_BAD;
    end else begin
      raw_s = signed'(raw_u[RAW_W-1:0]);
    end
  end

  // product and slew limits track their sources every cycle;
  // they are stable long before the frame end byte
  always_ff @(posedge clk) begin
    prod_r   <= PROD_W'(cfg.gain) * PROD_W'(raw_s);
    hi_lim_r <= (DATA_W+1)'(last_height_r) + SLEW_STEP;
    lo_lim_r <= (DATA_W+1)'(last_height_r) - SLEW_STEP;
  end

  // offset add, saturation, window and slew clamp
  always_comb begin
    acc    = (PROD_W+1)'(prod_r) + (PROD_W+1)'(cfg.offset);
    ovf    = !((&acc[PROD_W:DATA_W-1]) || !(|acc[PROD_W:DATA_W-1]));
    if (ovf) begin
      dist_val = acc[PROD_W] ? SAT_MIN : SAT_MAX;
    end else begin
      dist_val = acc[DATA_W-1:0];
    end
    in_win = (dist_val >= WIN_LO) && (dist_val <= WIN_HI);
    dist_x = (DATA_W+1)'(dist_val);
    h_x    = dist_x;
    if (cfg.slew_en) begin
      if (dist_x > hi_lim_r) begin
        h_x = hi_lim_r;
      end else if (dist_x < lo_lim_r) begin
        h_x = lo_lim_r;
      end
    end
  end

  // evaluation slot hands over to the output register
  assign fire  = eval_v_r && (!out_valid_r || out_ch.ready);
  assign stall = eval_v_r && out_valid_r && !out_ch.ready;

  always_comb begin
    eval_v_nxt    = eval_v_r;
    eval_proc_nxt = eval_proc_r;
    if (evt.valid) begin
      eval_v_nxt    = 1'b1;
      eval_proc_nxt = evt.proc;
    end else if (fire) begin
      eval_v_nxt = 1'b0;
    end
  end

  always_comb begin
    last_height_nxt = last_height_r;
    if (fire && eval_proc_r && in_win) begin
      last_height_nxt = h_x[DATA_W-1:0];
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_v_r      <= 1'b0;
      eval_proc_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      last_height_r <= '0;
    end else begin
      eval_v_r      <= eval_v_nxt;
      eval_proc_r   <= eval_proc_nxt;
      out_valid_r   <= out_valid_nxt;
      last_height_r <= last_height_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      processed_r <= eval_proc_r;
      distance_r  <= eval_proc_r ? dist_val : '0;
      updated_r   <= eval_proc_r && in_win;
      height_r    <= last_height_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.processed      = processed_r;
  assign out_ch.distance       = distance_r;
  assign out_ch.height_updated = updated_r;
  assign out_ch.height         = height_r;

endmodule

@@ hdl/sensor_frame_parse_calibrate.sv @@
// Sensor frame parser and calibrator. Takes one received byte per cycle,
// hunts for the preamble FE FE FE 68, checks an 8-bit additive checksum and
// the 0x16 end byte, and gives one result for every valid frame. Every
// fourth valid frame is calibrated as gain*raw+offset in signed Q16.16 with
// saturation; results inside 1000..2000 update the stored height, with an
// optional step limit of +-20. Bytes are taken at one per cycle while ready
// is high. The end byte loads an evaluation stage, which feeds the output
// register. The gain multiply runs off the captured raw bytes ahead of the
// end byte, so only the offset add and the clamps sit in the result path.
// Input ready drops only while one result waits in the output register and
// a second one waits behind it. Configuration writes are always taken.
module sensor_frame_parse_calibrate import sfpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sfpc_in_if.sink    in_ch,
  sfpc_out_if.source out_ch,
  sfpc_cfg_if.sink   cfg_ch
);

  cfg_regs_t         cfg_r, cfg_nxt;
  logic              in_accept;
  logic              stall;
  logic [BYTE_W-1:0] raw_lo, raw_hi;
  frame_evt_t        evt;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_GAIN:   cfg_nxt.gain    = cfg_ch.data;
        CFG_OFFSET: cfg_nxt.offset  = cfg_ch.data;
        CFG_SLEW:   cfg_nxt.slew_en = cfg_ch.data[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain    <= GAIN_RESET;
      cfg_r.offset  <= '0;
      cfg_r.slew_en <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input request handshake
  assign in_ch.ready = !stall;
  assign in_accept   = in_ch.valid && !stall;

  sfpc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .rx_byte (in_ch.rx_byte),
    .raw_lo  (raw_lo),
    .raw_hi  (raw_hi),
    .evt     (evt)
  );

  sfpc_calib u_calib (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .raw_lo (raw_lo),
    .raw_hi (raw_hi),
    .evt    (evt),
    .stall  (stall),
    .out_ch (out_ch)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import sfpc_pkg::*;

  // frame layout, indexed by the parser step that takes each byte
  localparam logic [3:0] POS_HUNT   = 4'd0;
  localparam logic [3:0] POS_SYNC   = 4'd3;
  localparam logic [3:0] POS_PAY0   = 4'd4;
  localparam logic [3:0] POS_RAW_LO = 4'd8;
  localparam logic [3:0] POS_RAW_HI = 4'd9;
  localparam logic [3:0] POS_CSUM   = 4'd12;
  localparam logic [3:0] POS_END    = 4'd13;
  localparam int         FRAME_LEN  = 14;

  localparam logic [7:0] LEAD_BYTE = 8'hFE;
  localparam logic [7:0] SYNC_MARK = 8'h68;
  localparam logic [7:0] TAIL_BYTE = 8'h16;

  // calibration limits, Q16.16 where fractional
  localparam logic [15:0] RAW_LOW_LIM  = 16'd479;
  localparam logic [15:0] RAW_HIGH_LIM = 16'd3180;
  localparam longint      RAW_FILL     = -64'sd5000;
  localparam longint      HGT_MIN      = 64'sd65536000;
  localparam longint      HGT_MAX      = 64'sd131072000;
  localparam longint      HGT_STEP     = 64'sd1310720;
  localparam longint      SAT_HI       = 64'sd2147483647;
  localparam longint      SAT_LO       = -64'sd2147483648;

  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_BYTES  = 110;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_PRE,
    FRAME_BAD_CSUM,
    FRAME_BAD_END,
    FRAME_CUT
  } frame_flaw_t;

  typedef struct {
    logic                     processed;
    logic signed [DATA_W-1:0] distance;
    logic                     height_updated;
    logic signed [DATA_W-1:0] height;
  } frame_result_t;

  logic clk;
  logic rst_n;

  sfpc_in_if  in_if();
  sfpc_out_if out_if();
  sfpc_cfg_if cfg_if();

  sensor_frame_parse_calibrate i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // calibration settings as the block should hold them
  logic signed [DATA_W-1:0] cal_gain   = 32'sh0001_0000;
  logic signed [DATA_W-1:0] cal_offset = 32'sh0;
  logic                     slew_on    = 1'b0;

  // parser and height state
  logic [3:0]               frame_pos     = POS_HUNT;
  logic [7:0]               run_sum       = 8'h00;
  logic [7:0]               raw_lo        = 8'h00;
  logic [7:0]               raw_hi        = 8'h00;
  logic [1:0]               frame_cnt     = 2'd0;
  logic signed [DATA_W-1:0] stored_height = 32'sh0;

  logic [7:0]    byte_queue [$];
  frame_result_t results_due [$];

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int in_shown      = 0;
  int in_taken      = 0;
  int err_cnt       = 0;
  int n_results     = 0;
  int n_calibrated  = 0;
  int n_height_upd  = 0;
  int n_settings    = 0;
  int stall_cycles  = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // advance the frame parser by one byte and queue the result it gives
  task automatic parse_byte(input logic [7:0] b);
    frame_result_t res;
    logic [15:0]   raw_u;
    longint        raw, cal_dist, h, prev;
    if (frame_pos == POS_HUNT || frame_pos > POS_END) begin
      frame_pos = (b == LEAD_BYTE) ? 4'd1 : POS_HUNT;
    end else if (frame_pos < POS_SYNC) begin
      frame_pos = (b == LEAD_BYTE) ? frame_pos + 4'd1 : POS_HUNT;
    end else if (frame_pos == POS_SYNC) begin
      frame_pos = (b == SYNC_MARK) ? POS_PAY0 : POS_HUNT;
    end else if (frame_pos < POS_CSUM) begin
      run_sum = (frame_pos == POS_PAY0) ? b : run_sum + b;
      if (frame_pos == POS_RAW_LO) raw_lo = b;
      if (frame_pos == POS_RAW_HI) raw_hi = b;
      frame_pos = frame_pos + 4'd1;
    end else if (frame_pos == POS_CSUM) begin
      frame_pos = (b == run_sum) ? POS_END : POS_HUNT;
    end else begin
      frame_pos = POS_HUNT;
      if (b == TAIL_BYTE) begin
        res.processed      = 1'b0;
        res.distance       = '0;
        res.height_updated = 1'b0;
        // only every fourth valid frame gets calibrated
        if (frame_cnt != 2'd3) begin
          frame_cnt = frame_cnt + 2'd1;
        end else begin
          frame_cnt = 2'd0;
          raw_u = {raw_hi, raw_lo};
          if (raw_u < RAW_LOW_LIM || raw_u > RAW_HIGH_LIM) begin
            raw = RAW_FILL;
          end else begin
            raw = longint'(raw_u);
          end
          cal_dist = longint'(cal_gain) * raw + longint'(cal_offset);
          if (cal_dist > SAT_HI) cal_dist = SAT_HI;
          if (cal_dist < SAT_LO) cal_dist = SAT_LO;
          res.processed = 1'b1;
          res.distance  = cal_dist[DATA_W-1:0];
          // window check, then optional step limit around the last height
          if (cal_dist >= HGT_MIN && cal_dist <= HGT_MAX) begin
            h = cal_dist;
            if (slew_on) begin
              prev = longint'(stored_height);
              if (h > prev + HGT_STEP) h = prev + HGT_STEP;
              if (h < prev - HGT_STEP) h = prev - HGT_STEP;
            end
            stored_height      = h[DATA_W-1:0];
            res.height_updated = 1'b1;
          end
        end
        res.height = stored_height;
        results_due.push_back(res);
      end
    end
  endtask

  // raw distance: mostly near the window, sometimes its edges or anything
  function automatic logic [15:0] pick_raw();
    logic [15:0] raw_marks [6] = '{16'd0, 16'd478, 16'd479, 16'd3180, 16'd3181, 16'hFFFF};
    case ($urandom_range(0, 9))
      0: return raw_marks[$urandom_range(0, 5)];
      1: return 16'($urandom);
      2, 3: return 16'($urandom_range(479, 3180));
      default: return 16'($urandom_range(900, 2100));
    endcase
  endfunction

  // build one frame with random payload, optionally damaged
  task automatic queue_frame(input logic [15:0] raw, input frame_flaw_t flaw);
    logic [7:0] fr [FRAME_LEN];
    logic [7:0] sum;
    logic [7:0] flip;
    int         n_keep;
    sum    = 8'h00;
    flip   = 8'($urandom_range(1, 255));
    n_keep = FRAME_LEN;
    for (int k = 0; k < POS_SYNC; k++) fr[k] = LEAD_BYTE;
    fr[POS_SYNC] = SYNC_MARK;
    for (int k = POS_PAY0; k < POS_CSUM; k++) begin
      fr[k] = 8'($urandom);
      if (k == POS_RAW_LO) fr[k] = raw[7:0];
      if (k == POS_RAW_HI) fr[k] = raw[15:8];
      sum += fr[k];
    end
    fr[POS_CSUM] = sum;
    fr[POS_END]  = TAIL_BYTE;
    case (flaw)
      FRAME_BAD_PRE:  fr[$urandom_range(0, POS_SYNC)] ^= flip;
      FRAME_BAD_CSUM: fr[POS_CSUM] ^= flip;
      FRAME_BAD_END:  fr[POS_END] ^= flip;
      FRAME_CUT:      n_keep = $urandom_range(1, FRAME_LEN - 1);
      default: ;
    endcase
    for (int k = 0; k < n_keep; k++) byte_queue.push_back(fr[k]);
  endtask

  // register write on the config channel, only while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_GAIN:   cal_gain   = val;
      CFG_OFFSET: cal_offset = val;
      CFG_SLEW:   slew_on    = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // wait for every byte to be taken and every result to arrive
  task automatic wait_idle();
    do @(negedge clk);
    while (byte_queue.size() != 0 || in_shown != in_taken || results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one setting: program the registers, then random frame traffic
  task automatic run_phase(input logic [DATA_W-1:0] gain, input logic [DATA_W-1:0] offs,
                           input logic slew, input int idle_pct, input int stall_pct);
    int         counted;
    int         pick;
    logic [7:0] b;
    counted = 0;
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_OFFSET, offs);
    write_reg(CFG_SLEW, {31'b0, slew});
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    n_settings++;
    while (counted < PHASE_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        queue_frame(pick_raw(), FRAME_GOOD);
        counted += FRAME_LEN;
      end else if (pick < 88) begin
        queue_frame(pick_raw(), frame_flaw_t'($urandom_range(1, 4)));
        counted += FRAME_LEN;
      end else begin
        // line noise, leaning toward preamble bytes
        repeat ($urandom_range(1, 6)) begin
          b = 8'($urandom);
          if ($urandom_range(0, 2) == 0) b = LEAD_BYTE;
          byte_queue.push_back(b);
        end
      end
    end
    wait_idle();
  endtask

  // byte driver and result receiver, both change on the falling edge
  always @(negedge clk) begin
    if (!in_if.valid || in_shown == in_taken) begin
      if (byte_queue.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= byte_queue.pop_front();
        in_shown++;
      end else begin
        in_if.valid   <= 1'b0;
        in_if.rx_byte <= 8'($urandom);
      end
    end
    out_if.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // accepted bytes feed the predictor, accepted results get checked
  always @(posedge clk) begin : monitor
    frame_result_t due;
    logic          in_fire, out_fire, cfg_fire;
    in_fire  = in_if.valid && in_if.ready;
    out_fire = out_if.valid && out_if.ready;
    cfg_fire = cfg_if.valid && cfg_if.ready;
    if (in_fire) begin
      parse_byte(in_if.rx_byte);
      in_taken++;
    end
    if (out_fire) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: processed %0b distance %0d height %0d",
               out_if.processed, out_if.distance, out_if.height);
        err_cnt++;
      end else begin
        due = results_due.pop_front();
        n_results++;
        if (due.processed) n_calibrated++;
        if (due.height_updated) n_height_upd++;
        if (out_if.processed !== due.processed) begin
          $error("processed: expected %0b, got %0b", due.processed, out_if.processed);
          err_cnt++;
        end
        if (out_if.distance !== due.distance) begin
          $error("distance: expected %0d, got %0d", due.distance, out_if.distance);
          err_cnt++;
        end
        if (out_if.height_updated !== due.height_updated) begin
          $error("height_updated: expected %0b, got %0b",
                 due.height_updated, out_if.height_updated);
          err_cnt++;
        end
        if (out_if.height !== due.height) begin
          $error("height: expected %0d, got %0d", due.height, out_if.height);
          err_cnt++;
        end
      end
    end
    // watchdog on handshake activity
    if (in_fire || out_fire || cfg_fire) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // reset, directed frames, then one random phase per setting
  initial begin
    logic [7:0] lead_in [11] = '{8'h00, 8'hFF, LEAD_BYTE, LEAD_BYTE, 8'h55,
                                 LEAD_BYTE, LEAD_BYTE, LEAD_BYTE, LEAD_BYTE,
                                 SYNC_MARK, 8'h00};
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_GAIN;
    cfg_if.data   = '0;
    rst_n         = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: byte extremes, broken preambles including an extra
    // lead byte, bad checksum, bad end byte, then four good frames with
    // out-of-range raw values in the skipped ones
    foreach (lead_in[k]) byte_queue.push_back(lead_in[k]);
    queue_frame(16'd1500, FRAME_BAD_CSUM);
    queue_frame(16'd1500, FRAME_BAD_END);
    queue_frame(16'd1500, FRAME_GOOD);
    queue_frame(16'd478, FRAME_GOOD);
    queue_frame(16'hFFFF, FRAME_GOOD);
    queue_frame(16'd1200, FRAME_GOOD);
    n_settings++;
    wait_idle();

    run_phase(32'h0001_0000, 32'h0000_0000, 1'b1, 0, 0);
    run_phase(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 60, 0);
    run_phase(32'h8000_0000, 32'h8000_0000, 1'b1, 0, 60);
    run_phase(32'h0000_8000, 32'd500 << 16, 1'b1, 27, 27);
    // zero gain puts a constant in the window so the step limit crawls
    run_phase(32'h0000_0000, 32'd1500 << 16, 1'b1, 0, 0);
    run_phase($urandom_range(20000, 131072), $urandom_range(0, 65536000) - 32768000,
              1'($urandom_range(0, 1)), 60, 0);
    run_phase($urandom, $urandom, 1'($urandom_range(0, 1)), 27, 27);
    run_phase(32'h0001_0000, 32'h0000_0000, 1'b0, 0, 60);

    $display("%0d bytes over %0d calibration settings, %0d frame results checked",
             in_taken, n_settings, n_results);
    $display("%0d frames calibrated, %0d height updates", n_calibrated, n_height_upd);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/sfpc_pkg.sv
hdl/sfpc_in_if.sv
hdl/sfpc_out_if.sv
hdl/sfpc_cfg_if.sv
hdl/sfpc_parser.sv
hdl/sfpc_calib.sv
hdl/sensor_frame_parse_calibrate.sv
tb/tb.sv
